/* rtl/lmcq_pkg.sv */
// Shared types, request codes and glyph tables for the LED matrix character queue.
// Used by lmcq_ctrl, lmcq_dp and led_matrix_char_queue_display; depends on nothing.
package lmcq_pkg;

  localparam int unsigned DEFAULT_RING_DEPTH = 128;

  // Request type codes on req_type_i.
  localparam logic [1:0] REQ_INIT   = 2'd0;
  localparam logic [1:0] REQ_PUT    = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  // This code is not assigned; a request carrying it is ignored.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Display driver register addresses.
  localparam logic [3:0] ROW_ADDR_BASE   = 4'd1;
  localparam logic [3:0] SETUP_ADDR_BASE = 4'd9;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [3:0] GLYPH_LOGO = 4'd10;

  localparam logic [1:0] SETUP_LAST_IDX = 2'd3;
  localparam logic [2:0] ROW_LAST_IDX   = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;        // latch the character of an accepted request
    logic       put;         // store the latched character in the ring
    logic       pop;         // read the oldest character and advance the read pointer
    logic       stop;        // stop the display timer
    logic       sel_logo;    // select the logo for the row writes
    logic       load;        // turn the character read from the ring into a glyph
    logic       emit_setup;  // issue one setup register write
    logic       emit_row;    // issue one row register write
    logic       last;        // final write of this request
    logic [2:0] idx;         // setup or row index
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic running;
    logic empty;
  } stat_t;

  function automatic logic [7:0] setup_value(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0:    val = 8'h00;
      2'd1:    val = 8'h03;
      2'd2:    val = 8'h07;
      default: val = 8'h01;
    endcase
    return val;
  endfunction

  // Row pattern of a glyph: 0 to 9 are digits, anything else the logo.
  function automatic logic [7:0] row_pattern(input logic [3:0] glyph, input logic [2:0] row);
    logic [63:0] rows;
    unique case (glyph)
      4'd0:    rows = 64'h1c22222222222_21c;
      4'd1:    rows = 64'h0818080808080_81c;
      4'd2:    rows = 64'h1c22220408102_03e;
      4'd3:    rows = 64'h1c22020c02022_21c;
      4'd4:    rows = 64'h040c1414241e0_404;
      4'd5:    rows = 64'h3e20203c02022_21c;
      4'd6:    rows = 64'h1c22203c22222_21c;
      4'd7:    rows = 64'h3e24040808080_808;
      4'd8:    rows = 64'h1c22221c22222_21c;
      4'd9:    rows = 64'h1c2222221e022_21c;
      default: rows = 64'h808080919bf51_111;
    endcase
    // The first row sits in the top byte.
    return rows[8'(7 - row) * 8 +: 8];
  endfunction

endpackage

/* rtl/lmcq_ctrl.sv */
// Controller state machine of the LED matrix character queue.
// Depends on lmcq_pkg; drives lmcq_dp through cmd_t and reads stat_t.
module lmcq_ctrl
  import lmcq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] req_type_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_TICK,
    S_LOAD,
    S_SETUP,
    S_ROWS
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.idx = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (start) begin
          cmd_o.take = 1'b1;
          unique case (req_type_i)
            REQ_INIT: state_d = S_SETUP;
            REQ_PUT:  state_d = S_PUT;
            REQ_TICK: state_d = S_TICK;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_IDLE;
      end
      S_TICK: begin
        priority if (!stat_i.running) begin
          state_d = S_IDLE;
        end else if (stat_i.empty) begin
          // Queue ran dry: show the logo and stop the timer.
          cmd_o.stop     = 1'b1;
          cmd_o.sel_logo = 1'b1;
          state_d        = S_ROWS;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_ROWS;
      end
      S_SETUP: begin
        cmd_o.emit_setup = 1'b1;
        cmd_o.sel_logo   = 1'b1;
        if (cnt_q[1:0] == SETUP_LAST_IDX) begin
          cnt_d   = '0;
          state_d = S_ROWS;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_ROWS: begin
        cmd_o.emit_row = 1'b1;
        cmd_o.last     = (cnt_q == ROW_LAST_IDX);
        cnt_d          = cnt_q + 3'd1;
        if (cnt_q == ROW_LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* rtl/lmcq_dp.sv */
// Datapath of the LED matrix character queue: character ring, pointers, timer
// flag, glyph selection and the output registers. Depends on lmcq_pkg.
module lmcq_dp
  import lmcq_pkg::*;
#(
  parameter int unsigned RING_DEPTH = DEFAULT_RING_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic [7:0] char_in_i,
  output stat_t      stat_o,
  output logic       strobe,
  output logic [3:0] reg_addr_o,
  output logic [7:0] reg_data_o,
  output logic       last_o
);

  localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

  logic [7:0]       ring_q [RING_DEPTH];
  logic [7:0]       rdata_q;
  logic [7:0]       char_q;
  logic [PTR_W-1:0] rp_q, wp_q;
  logic [PTR_W-1:0] rp_next, wp_next;
  logic             running_q;
  logic [3:0]       glyph_q;
  logic             strobe_q;
  logic [3:0]       addr_q;
  logic [7:0]       data_q;
  logic             last_q;

  assign rp_next = (rp_q == LAST_SLOT) ? '0 : rp_q + PTR_W'(1);
  assign wp_next = (wp_q == LAST_SLOT) ? '0 : wp_q + PTR_W'(1);

  assign stat_o.running = running_q;
  assign stat_o.empty   = (rp_q == wp_q);

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      ring_q[wp_q] <= char_q;
    end
    if (cmd_i.pop) begin
      rdata_q <= ring_q[rp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q      <= '0;
      wp_q      <= '0;
      running_q <= 1'b0;
    end else begin
      if (cmd_i.put) begin
        wp_q <= wp_next;
        // A full ring drops its oldest character.
        if (wp_next == rp_q) begin
          rp_q <= rp_next;
        end
        if (rp_q == wp_q) begin
          running_q <= 1'b1;
        end
      end
      if (cmd_i.pop) begin
        rp_q <= rp_next;
      end
      if (cmd_i.stop) begin
        running_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      char_q <= char_in_i;
    end
    if (cmd_i.sel_logo) begin
      glyph_q <= GLYPH_LOGO;
    end else if (cmd_i.load) begin
      if (rdata_q >= CHAR_ZERO && rdata_q <= CHAR_NINE) begin
        glyph_q <= rdata_q[3:0];
      end else begin
        glyph_q <= GLYPH_LOGO;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_setup | cmd_i.emit_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_setup) begin
      addr_q <= SETUP_ADDR_BASE + {2'b00, cmd_i.idx[1:0]};
      data_q <= setup_value(cmd_i.idx[1:0]);
      last_q <= 1'b0;
    end else if (cmd_i.emit_row) begin
      addr_q <= ROW_ADDR_BASE + {1'b0, cmd_i.idx};
      data_q <= row_pattern(glyph_q, cmd_i.idx);
      last_q <= cmd_i.last;
    end
  end

  assign strobe     = strobe_q;
  assign reg_addr_o = addr_q;
  assign reg_data_o = data_q;
  assign last_o     = last_q;

endmodule

/* rtl/led_matrix_char_queue_display.sv */
// Top level of the LED matrix character queue display.
// Depends on lmcq_pkg, lmcq_ctrl and lmcq_dp.
//
// Use: a request (req_type_i, char_in_i) is taken at a rising clock edge where
// start is high and busy is low. Init requests produce four setup writes and
// then the eight logo rows; put requests store one character in the ring and
// produce nothing; tick requests, while the display timer runs, produce eight
// row writes for the oldest character (or the logo, stopping the timer, when
// the ring is empty). Each register write appears on reg_addr_o, reg_data_o
// and last_o for exactly one cycle with strobe high; last_o marks the final
// write of a request. The receiver cannot hold writes off, so there is no
// stall path: the controller simply paces the writes one per cycle.
// Sequence, from acceptance to the next possible acceptance: a put passes
// through S_PUT, a tick while stopped through S_TICK, a tick on an empty ring
// through S_TICK and S_ROWS, a tick that pops a character through S_TICK,
// S_LOAD (for the registered ring read) and S_ROWS, and an init through
// S_SETUP and S_ROWS. Each write is registered from the state that issues it;
// the last one shows in the first cycle that busy is low again.
// Reset clears the pointers, stops the timer and idles the controller; the
// ring contents are not cleared, as only written slots are ever read.
module led_matrix_char_queue_display
  import lmcq_pkg::*;
#(
  parameter int unsigned RING_DEPTH = DEFAULT_RING_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type_i,
  input  logic [7:0] char_in_i,
  output logic       strobe,
  output logic [3:0] reg_addr_o,
  output logic [7:0] reg_data_o,
  output logic       last_o
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences each request; the datapath holds all storage.
  lmcq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  lmcq_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .char_in_i  (char_in_i),
    .stat_o     (stat),
    .strobe     (strobe),
    .reg_addr_o (reg_addr_o),
    .reg_data_o (reg_data_o),
    .last_o     (last_o)
  );

`ifndef SYNTHESIS
  // Every write is the registered result of work done while busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> $past(busy))
  else $error("write issued without a request in progress");

  // Nothing follows the final write of a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && last_o) |=> !strobe)
  else $error("write issued after the final write of a request");

  // A put produces no writes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == REQ_PUT) |=> busy ##1 !strobe)
  else $error("put request produced a register write");
`endif

endmodule
